// ----- hw/rtl/ils_pkg.sv -----
// Shared definitions for the indexed list store: command codes and the
// payload structs carried by the request and response channels.
// No dependencies.
`timescale 1ns / 1ps

package ils_pkg;

    // Command codes carried in the request word.
    localparam logic [1:0] CMD_RETRIEVE = 2'd0;
    localparam logic [1:0] CMD_INSERT   = 2'd1;
    localparam logic [1:0] CMD_REMOVE   = 2'd2;

    // Request word.
    typedef struct packed {
        logic [1:0]  command;
        logic [6:0]  position;
        logic [31:0] new_word;
    } ils_req_t;

    // Response word.
    typedef struct packed {
        logic        ok;
        logic [31:0] read_word;
        logic [6:0]  length;
    } ils_rsp_t;

endpackage

// ----- hw/rtl/ils_if.sv -----
// Valid/ready channel interfaces for request and response words.
// Depends on ils_pkg.
`timescale 1ns / 1ps

interface ils_req_if;
    logic              valid;
    logic              ready;
    ils_pkg::ils_req_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface ils_rsp_if;
    logic              valid;
    logic              ready;
    ils_pkg::ils_rsp_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ----- hw/rtl/ils_ram.sv -----
// Generic simple dual-port RAM: one write port, one read port with a
// registered read. No dependencies.
`timescale 1ns / 1ps

module ils_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port and registered read port; read data holds while idle.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

// ----- hw/rtl/indexed_list_store_unit.sv -----
// Indexed list store: an ordered list of up to CAPACITY words addressed by
// 1-based position, with retrieve, insert and remove commands; one response
// word per request word. A retrieve passes through S_READ and an append at
// the end through S_PUT on its way to S_RESP; a failed command or a removal
// of the last entry goes straight to S_RESP. An insert that moves entries
// runs S_SHIFT, S_DRAIN and S_PUT and a remove that moves entries runs
// S_SHIFT and S_DRAIN before S_RESP: the entry shift walks the single RAM
// one entry per cycle, reading one entry while writing back the one read
// before. A new request is taken once the previous one has left the
// sequencer, even while its response still waits in the output register.
// The RAM needs no clearing pass after reset. Depends on ils_pkg, ils_if
// and ils_ram.
`timescale 1ns / 1ps

module indexed_list_store_unit #(
    parameter int CAPACITY   = 64,
    parameter int WORD_WIDTH = 32
) (
    input  logic      clk,
    input  logic      rst_n,
    ils_req_if.sink   req,
    ils_rsp_if.source rsp
);

    import ils_pkg::*;

    localparam int AW    = $clog2(CAPACITY);
    localparam int CW    = $clog2(CAPACITY + 1);
    localparam int CMP_W = ((CW > 7) ? CW : 7) + 1;
    localparam logic [CMP_W-1:0] CAP_C = CMP_W'(CAPACITY);

    typedef enum logic [2:0] {
        S_IDLE,
        S_READ,
        S_SHIFT,
        S_DRAIN,
        S_PUT,
        S_RESP
    } state_t;

    state_t                state_reg, state_next;
    logic [1:0]            cmd_reg, cmd_next;
    logic [AW-1:0]         idx_reg, idx_next;
    logic [WORD_WIDTH-1:0] word_reg, word_next;
    logic                  ok_reg, ok_next;
    logic [CW-1:0]         cnt_reg, cnt_next;
    logic [AW-1:0]         ptr_reg, ptr_next;
    logic [AW-1:0]         last_reg, last_next;
    logic [AW-1:0]         waddr_reg, waddr_next;
    logic                  first_reg, first_next;
    logic                  rsp_valid_reg, rsp_valid_next;
    ils_rsp_t              rsp_data_reg, rsp_data_next;

    logic                  ram_wr_en;
    logic [AW-1:0]         ram_wr_addr;
    logic [WORD_WIDTH-1:0] ram_wr_data;
    logic                  ram_rd_en;
    logic [AW-1:0]         ram_rd_addr;
    logic [WORD_WIDTH-1:0] ram_rd_data;

    logic [CMP_W-1:0]      pos_w;
    logic [CMP_W-1:0]      cnt_w;
    logic                  pos_ok_rd;
    logic                  pos_ok_ins;
    logic [63:0]           new_word_w;
    logic [63:0]           rd_word_w;
    logic                  is_insert;
    logic                  rsp_space;

    ils_ram #(
        .WIDTH (WORD_WIDTH),
        .DEPTH (CAPACITY)
    ) u_ram (
        .clk     (clk),
        .wr_en   (ram_wr_en),
        .wr_addr (ram_wr_addr),
        .wr_data (ram_wr_data),
        .rd_en   (ram_rd_en),
        .rd_addr (ram_rd_addr),
        .rd_data (ram_rd_data)
    );

    // Position checks against the current length.
    assign pos_w      = CMP_W'(req.data.position);
    assign cnt_w      = CMP_W'(cnt_reg);
    assign pos_ok_rd  = (pos_w != '0) && (pos_w <= cnt_w);
    assign pos_ok_ins = (pos_w != '0) && (pos_w <= cnt_w + CMP_W'(1)) && (cnt_w < CAP_C);

    // Word width conversions between the channel and the store.
    assign new_word_w = 64'(req.data.new_word);
    assign rd_word_w  = 64'(ram_rd_data);
    assign is_insert  = (cmd_reg == CMD_INSERT);
    assign rsp_space  = !rsp_valid_reg || rsp.ready;

    // RAM port control follows the sequencer state.
    always_comb
    begin
        ram_rd_en   = 1'b0;
        ram_rd_addr = ptr_reg;
        ram_wr_en   = 1'b0;
        ram_wr_addr = waddr_reg;
        ram_wr_data = ram_rd_data;
        unique case (state_reg)
            S_READ:
            begin
                ram_rd_en   = 1'b1;
                ram_rd_addr = idx_reg;
            end
            S_SHIFT:
            begin
                ram_rd_en = 1'b1;
                ram_wr_en = !first_reg;
            end
            S_DRAIN:
            begin
                ram_wr_en = 1'b1;
            end
            S_PUT:
            begin
                ram_wr_en   = 1'b1;
                ram_wr_addr = idx_reg;
                ram_wr_data = word_reg;
            end
            default:
            begin
            end
        endcase
    end

    // Sequencer next state.
    always_comb
    begin
        state_next     = state_reg;
        cmd_next       = cmd_reg;
        idx_next       = idx_reg;
        word_next      = word_reg;
        ok_next        = ok_reg;
        cnt_next       = cnt_reg;
        ptr_next       = ptr_reg;
        last_next      = last_reg;
        waddr_next     = waddr_reg;
        first_next     = first_reg;
        rsp_valid_next = rsp_valid_reg && !rsp.ready;
        rsp_data_next  = rsp_data_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                if (req.valid)
                begin
                    cmd_next   = req.data.command;
                    idx_next   = AW'(pos_w - CMP_W'(1));
                    word_next  = new_word_w[WORD_WIDTH-1:0];
                    ok_next    = 1'b0;
                    first_next = 1'b1;
                    state_next = S_RESP;
                    case (req.data.command)
                        CMD_RETRIEVE:
                        begin
                            if (pos_ok_rd)
                            begin
                                ok_next    = 1'b1;
                                state_next = S_READ;
                            end
                        end
                        CMD_INSERT:
                        begin
                            if (pos_ok_ins)
                            begin
                                ok_next = 1'b1;
                                if (pos_w == cnt_w + CMP_W'(1))
                                begin
                                    // Append at the end: nothing to move.
                                    state_next = S_PUT;
                                end
                                else
                                begin
                                    ptr_next   = AW'(cnt_w - CMP_W'(1));
                                    last_next  = AW'(pos_w - CMP_W'(1));
                                    state_next = S_SHIFT;
                                end
                            end
                        end
                        CMD_REMOVE:
                        begin
                            if (pos_ok_rd)
                            begin
                                ok_next = 1'b1;
                                if (pos_w == cnt_w)
                                begin
                                    // Last entry removed: nothing to move.
                                    cnt_next = cnt_reg - CW'(1);
                                end
                                else
                                begin
                                    ptr_next   = AW'(pos_w);
                                    last_next  = AW'(cnt_w - CMP_W'(1));
                                    state_next = S_SHIFT;
                                end
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            S_READ:
            begin
                state_next = S_RESP;
            end
            S_SHIFT:
            begin
                // Read one entry while writing back the one read before.
                first_next = 1'b0;
                waddr_next = is_insert ? ptr_reg + AW'(1) : ptr_reg - AW'(1);
                ptr_next   = is_insert ? ptr_reg - AW'(1) : ptr_reg + AW'(1);
                if (ptr_reg == last_reg)
                begin
                    state_next = S_DRAIN;
                end
            end
            S_DRAIN:
            begin
                if (is_insert)
                begin
                    state_next = S_PUT;
                end
                else
                begin
                    cnt_next   = cnt_reg - CW'(1);
                    state_next = S_RESP;
                end
            end
            S_PUT:
            begin
                cnt_next   = cnt_reg + CW'(1);
                state_next = S_RESP;
            end
            S_RESP:
            begin
                if (rsp_space)
                begin
                    rsp_valid_next          = 1'b1;
                    rsp_data_next.ok        = ok_reg;
                    rsp_data_next.read_word = (ok_reg && (cmd_reg == CMD_RETRIEVE))
                                              ? rd_word_w[31:0] : 32'd0;
                    rsp_data_next.length    = cnt_w[6:0];
                    state_next              = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // State and registered outputs.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            cnt_reg       <= '0;
            first_reg     <= 1'b1;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            first_reg     <= first_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        cmd_reg      <= cmd_next;
        idx_reg      <= idx_next;
        word_reg     <= word_next;
        ok_reg       <= ok_next;
        ptr_reg      <= ptr_next;
        last_reg     <= last_next;
        waddr_reg    <= waddr_next;
        rsp_data_reg <= rsp_data_next;
    end

    assign req.ready = (state_reg == S_IDLE);
    assign rsp.valid = rsp_valid_reg;
    assign rsp.data  = rsp_data_reg;

`ifndef NO_ASSERTIONS
    // The length never exceeds the capacity.
    a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        CMP_W'(cnt_reg) <= CAP_C)
        else $error("entry count above capacity");

    // The store is never written while the sequencer is idle.
    a_no_idle_write: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_IDLE) |-> !ram_wr_en)
        else $error("RAM write while idle");

    // Every write lands inside the store.
    a_wr_range: assert property (@(posedge clk) disable iff (!rst_n)
        ram_wr_en |-> (CMP_W'(ram_wr_addr) < CAP_C))
        else $error("RAM write address out of range");

    // The length changes only as a removal of the last entry is accepted or as a command finishes its RAM work.
    a_cnt_change: assert property (@(posedge clk) disable iff (!rst_n)
        (cnt_reg != $past(cnt_reg)) |->
            ($past(state_reg) == S_IDLE || $past(state_reg) == S_DRAIN ||
             $past(state_reg) == S_PUT))
        else $error("entry count changed outside a command end");
`endif

endmodule

// ----- sim/indexed_list_store_unit_tb.sv -----
// Self-checking testbench for indexed_list_store_unit: drives request words with
// random idle bursts, predicts every response in a scoreboard class and compares it.
// Depends on ils_pkg, ils_if and the indexed_list_store_unit RTL.
`timescale 1ns / 1ps

module indexed_list_store_unit_tb;

    import ils_pkg::*;

    localparam int CAPACITY   = 64;
    localparam int WORD_WIDTH = 32;
    localparam logic [31:0] WORD_MASK =
        (WORD_WIDTH >= 32) ? 32'hFFFF_FFFF : ((32'd1 << WORD_WIDTH) - 32'd1);

    // Command code with no operation behind it.
    localparam logic [1:0] CMD_UNUSED = 2'd3;

    // Stimulus shaping modes for the random part; any other mode is a mix.
    localparam int MODE_GROW   = 0;
    localparam int MODE_SHRINK = 1;

    localparam int RANDOM_ITEMS = 1925;
    localparam int QUIET_AFTER  = 1700;
    localparam int STALL_AT     = 500;
    localparam int STALL_CYCLES = 300;
    localparam int TAIL_CYCLES  = 100;
    localparam int CYCLE_LIMIT  = 800000;

    // Scoreboard: keeps its own copy of the list and the responses it still awaits.
    class list_scoreboard;
        logic [31:0] entries [CAPACITY];
        int unsigned fill;
        ils_rsp_t    awaited [$];
        int          errors;

        function new();
            fill   = 0;
            errors = 0;
            foreach (entries[i]) entries[i] = '0;
        endfunction

        task report(string what, logic [31:0] got, logic [31:0] want);
            errors++;
            $display("mismatch %0d at %0t ns: %s got %h want %h",
                     errors, $time, what, got, want);
        endtask

        // Applies one accepted request word to the list copy and queues its response.
        function void note_request(ils_req_t w);
            ils_rsp_t    exp;
            int unsigned pos;
            int          i;
            pos = {25'd0, w.position};
            exp = '0;
            case (w.command)
                CMD_RETRIEVE:
                begin
                    if (pos >= 1 && pos <= fill)
                    begin
                        exp.read_word = entries[pos - 1];
                        exp.ok        = 1'b1;
                    end
                end
                CMD_INSERT:
                begin
                    if (pos >= 1 && pos <= fill + 1 && fill < CAPACITY)
                    begin
                        for (i = fill; i >= int'(pos); i--)
                            entries[i] = entries[i - 1];
                        entries[pos - 1] = w.new_word & WORD_MASK;
                        fill++;
                        exp.ok = 1'b1;
                    end
                end
                CMD_REMOVE:
                begin
                    if (pos >= 1 && pos <= fill)
                    begin
                        for (i = pos; i < int'(fill); i++)
                            entries[i - 1] = entries[i];
                        fill--;
                        exp.ok = 1'b1;
                    end
                end
                default: ;
            endcase
            exp.length = fill[6:0];
            awaited.push_back(exp);
        endfunction

        // Compares one accepted response word with the oldest awaited one.
        task check_response(ils_rsp_t w);
            ils_rsp_t exp;
            if (awaited.size() == 0)
            begin
                report("unexpected response, length", {25'd0, w.length}, 32'd0);
            end
            else
            begin
                exp = awaited.pop_front();
                if (w.ok !== exp.ok)
                    report("ok", {31'd0, w.ok}, {31'd0, exp.ok});
                if (w.read_word !== exp.read_word)
                    report("read_word", w.read_word, exp.read_word);
                if (w.length !== exp.length)
                    report("length", {25'd0, w.length}, {25'd0, exp.length});
            end
        endtask
    endclass

    logic clk;
    logic rst_n;

    ils_req_if req_ch ();
    ils_rsp_if rsp_ch ();

    list_scoreboard sb;

    int cycle_count;
    int accepted_count;
    int sent_count;
    bit quiet;

    indexed_list_store_unit #(
        .CAPACITY   (CAPACITY),
        .WORD_WIDTH (WORD_WIDTH)
    ) uut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch)
    );

    // Clock: 10 ns period, starting low.
    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // Run limit.
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    // Watch both channels at the rising edge.
    always @(posedge clk)
    begin
        if (rst_n && req_ch.valid && req_ch.ready)
        begin
            sb.note_request(req_ch.data);
            accepted_count++;
        end
        if (rst_n && rsp_ch.valid && rsp_ch.ready)
            sb.check_response(rsp_ch.data);
    end

    // Receiver: ready in random stretches, one long hold-off, steady at the end.
    initial
    begin : receiver
        int  left;
        bit  stalled;
        left    = 0;
        stalled = 0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (left > 0)
            begin
                left--;
            end
            else if (!stalled && accepted_count >= STALL_AT)
            begin
                stalled = 1;
                left    = STALL_CYCLES - 1;
                rsp_ch.ready <= 1'b0;
            end
            else if (quiet)
            begin
                rsp_ch.ready <= 1'b1;
            end
            else if ($urandom_range(0, 3) == 0)
            begin
                left = $urandom_range(0, 8);
                rsp_ch.ready <= 1'b0;
            end
            else
            begin
                left = $urandom_range(0, 39);
                rsp_ch.ready <= 1'b1;
            end
        end
    end

    // Offers one request word, called at a falling edge; returns at the falling
    // edge after it was taken.
    task send_word(logic [1:0] command, logic [6:0] position, logic [31:0] new_word);
        int gap;
        if (!quiet && $urandom_range(0, 5) == 0)
        begin
            gap = $urandom_range(1, 9);
            req_ch.valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        req_ch.valid         <= 1'b1;
        req_ch.data.command  <= command;
        req_ch.data.position <= position;
        req_ch.data.new_word <= new_word;
        forever
        begin
            @(posedge clk);
            if (req_ch.ready)
                break;
        end
        sent_count++;
        @(negedge clk);
    endtask

    // Picks a random request, mostly well formed against the current list length.
    task send_random(int mode);
        int          r;
        int          cmd_pick;
        int          top;
        logic [1:0]  command;
        logic [6:0]  position;
        logic [31:0] new_word;
        r = $urandom_range(0, 99);
        case ($urandom_range(0, 7))
            0:       new_word = 32'd0;
            1:       new_word = 32'hFFFF_FFFF;
            default: new_word = $urandom;
        endcase
        if (r < 8)
        begin
            command  = 2'($urandom_range(0, 3));
            position = 7'($urandom_range(0, 127));
        end
        else
        begin
            cmd_pick = $urandom_range(0, 99);
            case (mode)
                MODE_GROW:
                    command = (cmd_pick < 65) ? CMD_INSERT :
                              (cmd_pick < 80) ? CMD_REMOVE : CMD_RETRIEVE;
                MODE_SHRINK:
                    command = (cmd_pick < 15) ? CMD_INSERT :
                              (cmd_pick < 80) ? CMD_REMOVE : CMD_RETRIEVE;
                default:
                    command = (cmd_pick < 35) ? CMD_INSERT :
                              (cmd_pick < 65) ? CMD_REMOVE : CMD_RETRIEVE;
            endcase
            top = (command == CMD_INSERT) ? sb.fill + 1 : sb.fill;
            if (top < 1)
                top = 1;
            case ($urandom_range(0, 3))
                0:       position = 7'd1;
                1:       position = top[6:0];
                default: position = 7'($urandom_range(1, top));
            endcase
        end
        send_word(command, position, new_word);
    endtask

    initial
    begin : main
        int i;
        rst_n        = 1'b0;
        req_ch.valid = 1'b0;
        req_ch.data  = '0;
        rsp_ch.ready = 1'b0;
        cycle_count    = 0;
        accepted_count = 0;
        sent_count     = 0;
        quiet          = 0;
        sb = new();

        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // Directed part: empty list, bad positions, both word extremes, edges.
        send_word(CMD_RETRIEVE, 7'd1, 32'h1234_5678);
        send_word(CMD_REMOVE,   7'd1, 32'd0);
        send_word(CMD_INSERT,   7'd0, 32'hDEAD_BEEF);
        send_word(CMD_INSERT,   7'd2, 32'hDEAD_BEEF);
        send_word(CMD_INSERT,   7'd1, 32'd0);
        send_word(CMD_INSERT,   7'd1, 32'hFFFF_FFFF);
        send_word(CMD_INSERT,   7'd3, 32'hA5A5_A5A5);
        send_word(CMD_INSERT,   7'd2, 32'h5A5A_5A5A);
        send_word(CMD_RETRIEVE, 7'd1, 32'd0);
        send_word(CMD_RETRIEVE, 7'd2, 32'd0);
        send_word(CMD_RETRIEVE, 7'd3, 32'd0);
        send_word(CMD_RETRIEVE, 7'd4, 32'hFFFF_FFFF);
        send_word(CMD_RETRIEVE, 7'd0, 32'd0);
        send_word(CMD_RETRIEVE, 7'd5, 32'd0);
        send_word(CMD_RETRIEVE, 7'd127, 32'd0);
        send_word(CMD_UNUSED,   7'd1, 32'hFFFF_FFFF);
        send_word(CMD_INSERT,   7'd6, 32'h0F0F_0F0F);
        send_word(CMD_INSERT,   7'd127, 32'hF0F0_F0F0);
        send_word(CMD_REMOVE,   7'd5, 32'd0);
        send_word(CMD_REMOVE,   7'd0, 32'd0);
        send_word(CMD_REMOVE,   7'd2, 32'd0);
        send_word(CMD_RETRIEVE, 7'd2, 32'd0);
        send_word(CMD_REMOVE,   7'd3, 32'd0);
        send_word(CMD_REMOVE,   7'd1, 32'd0);
        send_word(CMD_RETRIEVE, 7'd1, 32'd0);

        // Random part: alternate growing to a full list, draining it, and a mix.
        for (i = 0; i < RANDOM_ITEMS; i++)
        begin
            if (sent_count >= QUIET_AFTER)
                quiet = 1;
            send_random((i / 150) % 3);
        end
        req_ch.valid <= 1'b0;

        // Drain, then give the block time to show any stray response.
        while (sb.awaited.size() != 0)
            @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);

        if (sb.awaited.size() != 0)
            sb.report("responses never seen", sb.awaited.size(), 32'd0);

        if (sb.errors == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
